// ----- rtl/scfa_pkg.sv -----
// Shared types and constants for the size-class free-run allocator.
// No dependencies.
package scfa_pkg;

  // Class numbers are 5 bits wide; all ones means "no class"
  localparam int unsigned CLASS_W = 5;
  localparam logic [CLASS_W-1:0] NO_CLASS = 5'd31;

  // Result status codes
  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_ADDED   = 3'd2,
    ST_DUP     = 3'd3,
    ST_FULL    = 3'd4,
    ST_BAD     = 3'd5
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_FREE_RD,
    S_FREE_CMP,
    S_FREE_ADD,
    S_ALLOC_INIT,
    S_ALLOC_CHK,
    S_ALLOC_RD,
    S_ALLOC_CMP,
    S_LOWER
  } state_e;

endpackage

// ----- rtl/scfa_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module scfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/scfa_class_map.sv -----
// Maps a page count to its size class; the class output is registered.
// Depends on scfa_pkg.
module scfa_class_map
  import scfa_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        pages_i,
  input  logic [4:0]         base_i,
  output logic [CLASS_W-1:0] cls_o
);

  localparam logic [5:0] LAST_CLASS = 6'(NUM_CLASSES - 1);

  logic [31:0]        pm1;
  logic [5:0]         need;
  logic [5:0]         diff;
  logic [CLASS_W-1:0] cls_d;
  logic [CLASS_W-1:0] cls_q;

  // Bits needed for pages-1 gives the smallest power of two that holds the run
  always_comb begin
    pm1  = pages_i - 32'd1;
    need = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (pm1[i]) begin
        need = 6'(i + 1);
      end
    end
    diff = need - {1'b0, base_i};
    if (need <= {1'b0, base_i}) begin
      cls_d = '0;
    end else if (diff >= LAST_CLASS) begin
      cls_d = CLASS_W'(LAST_CLASS);
    end else begin
      cls_d = diff[CLASS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= '0;
    end else begin
      cls_q <= cls_d;
    end
  end

  assign cls_o = cls_q;

endmodule

// ----- rtl/size_class_free_chunk_allocator.sv -----
// Segregated free-list page-run allocator: controller, list state and run memories.
// Depends on scfa_pkg, scfa_ram, scfa_class_map.
//
//  channel   handshake                   payload
//  request   start & !busy               req_type_i, start_page_i, page_count_i
//  result    out_valid_o (one cycle)     status_o, granted_page_o, granted_count_o
//  config    cfg_valid_i & cfg_ready_o   cfg_data_i (base_class_log2)
//
// Bad requests are answered straight from the idle state. A free scans the pool
// slots in order through the run memory, reading and checking each, and stops early
// on a duplicate. An allocate steps over empty classes, reads and checks each run it
// visits, and walks down through the classes when the top class is lowered.
// Reset clears all valid bits at once; no clearing pass. Results cannot stall.
module size_class_free_chunk_allocator
  import scfa_pkg::*;
#(
  parameter int unsigned NUM_CLASSES  = 24,
  parameter int unsigned POOL_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [31:0] start_page_i,
  input  logic [31:0] page_count_i,
  output logic        out_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] granted_page_o,
  output logic [31:0] granted_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam int unsigned AW  = $clog2(POOL_ENTRIES);
  localparam int unsigned CIW = $clog2(NUM_CLASSES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_ENTRIES - 1);
  localparam logic [CLASS_W-1:0] NC = CLASS_W'(NUM_CLASSES);

  state_e state_q, state_d;

  logic               type_q, type_d;
  logic [31:0]        spage_q, spage_d;
  logic [31:0]        pages_q, pages_d;
  logic [CLASS_W-1:0] c_q, c_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [AW-1:0]      prev_q, prev_d;
  logic               have_prev_q, have_prev_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      slot_q, slot_d;
  logic               found_q, found_d;
  logic [CLASS_W-1:0] top_q, top_d;
  logic [4:0]         base_q, base_d;

  logic [POOL_ENTRIES-1:0] in_use_q, in_use_d;
  logic [POOL_ENTRIES-1:0] lvalid_q, lvalid_d;
  logic [NUM_CLASSES-1:0]  nonempty_q, nonempty_d;
  logic [AW-1:0]           head_q [NUM_CLASSES];
  logic [AW-1:0]           head_d [NUM_CLASSES];
  logic [AW-1:0]           tail_q [NUM_CLASSES];
  logic [AW-1:0]           tail_d [NUM_CLASSES];

  logic        ovalid_q, ovalid_d;
  status_e     status_q, status_d;
  logic [31:0] gp_q, gp_d;
  logic [31:0] gc_q, gc_d;

  // Memory ports
  logic          run_we;
  logic [AW-1:0] run_addr;
  logic [63:0]   run_rd;
  logic          lk_we;
  logic [AW-1:0] lk_addr;
  logic [AW-1:0] lk_wdata;
  logic [AW-1:0] lk_rd;

  logic [CLASS_W-1:0] cls;
  logic [CIW-1:0]     cix;
  logic [CIW-1:0]     fix;
  logic [31:0]        rd_start;
  logic [31:0]        rd_len;
  logic               has_next;

  // Run start and length, one word per slot
  scfa_ram #(.WIDTH(64), .DEPTH(POOL_ENTRIES)) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (run_we),
    .addr_i (run_addr),
    .wdata_i({spage_q, pages_q}),
    .rdata_o(run_rd)
  );

  // Successor slot of each run in its class list
  scfa_ram #(.WIDTH(AW), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lk_we),
    .addr_i (lk_addr),
    .wdata_i(lk_wdata),
    .rdata_o(lk_rd)
  );

  scfa_class_map #(.NUM_CLASSES(NUM_CLASSES)) u_class_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pages_i(pages_q),
    .base_i (base_q),
    .cls_o  (cls)
  );

  assign rd_start = run_rd[63:32];
  assign rd_len   = run_rd[31:0];
  assign cix      = c_q[CIW-1:0];
  assign fix      = cls[CIW-1:0];
  assign has_next = lvalid_q[cur_q];

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Next state and list updates
  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    spage_d     = spage_q;
    pages_d     = pages_q;
    c_d         = c_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    found_d     = found_q;
    top_d       = top_q;
    base_d      = base_q;
    in_use_d    = in_use_q;
    lvalid_d    = lvalid_q;
    nonempty_d  = nonempty_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ovalid_d    = 1'b0;
    status_d    = status_q;
    gp_d        = gp_q;
    gc_d        = gc_q;
    run_we      = 1'b0;
    run_addr    = cur_q;
    lk_we       = 1'b0;
    lk_addr     = cur_q;
    lk_wdata    = '0;

    if (cfg_valid_i) begin
      base_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          type_d  = req_type_i;
          spage_d = start_page_i;
          pages_d = page_count_i;
          if ((page_count_i == 32'd0) || (req_type_i && (start_page_i == '1))) begin
            ovalid_d = 1'b1;
            status_d = ST_BAD;
            gp_d     = '0;
            gc_d     = '0;
          end else begin
            state_d = S_CLASS;
          end
        end
      end

      S_CLASS: begin
        if (type_q) begin
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = S_FREE_RD;
        end else begin
          state_d = S_ALLOC_INIT;
        end
      end

      // Duplicate scan and lowest free slot search
      S_FREE_RD: begin
        run_addr = cnt_q;
        state_d  = S_FREE_CMP;
      end

      S_FREE_CMP: begin
        if (in_use_q[cnt_q] && (rd_start == spage_q)) begin
          ovalid_d = 1'b1;
          status_d = ST_DUP;
          gp_d     = '0;
          gc_d     = '0;
          state_d  = S_IDLE;
        end else begin
          if (!in_use_q[cnt_q] && !found_q) begin
            found_d = 1'b1;
            slot_d  = cnt_q;
          end
          if (cnt_q == LAST_SLOT) begin
            state_d = S_FREE_ADD;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_FREE_RD;
          end
        end
      end

      // Store the run and append it to its class, or report full when no slot is free
      S_FREE_ADD: begin
        ovalid_d = 1'b1;
        gp_d     = '0;
        gc_d     = '0;
        state_d  = S_IDLE;
        if (!found_q) begin
          status_d = ST_FULL;
        end else begin
          status_d         = ST_ADDED;
          run_we           = 1'b1;
          run_addr         = slot_q;
          in_use_d[slot_q] = 1'b1;
          lvalid_d[slot_q] = 1'b0;
          if (!nonempty_q[fix]) begin
            nonempty_d[fix] = 1'b1;
            head_d[fix]     = slot_q;
            tail_d[fix]     = slot_q;
            if ((top_q == NO_CLASS) || (top_q < cls)) begin
              top_d = cls;
            end
          end else begin
            lk_we                 = 1'b1;
            lk_addr               = tail_q[fix];
            lk_wdata              = slot_q;
            lvalid_d[tail_q[fix]] = 1'b1;
            tail_d[fix]           = slot_q;
          end
        end
      end

      S_ALLOC_INIT: begin
        c_d     = cls;
        state_d = S_ALLOC_CHK;
      end

      // Step through classes up to the top class; report no fit once past it
      S_ALLOC_CHK: begin
        if ((top_q == NO_CLASS) || (top_q >= NC) || (top_q < c_q)) begin
          ovalid_d = 1'b1;
          status_d = ST_NO_FIT;
          gp_d     = '0;
          gc_d     = '0;
          state_d  = S_IDLE;
        end else if (!nonempty_q[cix]) begin
          c_d = c_q + 1'b1;
        end else begin
          cur_d       = head_q[cix];
          have_prev_d = 1'b0;
          state_d     = S_ALLOC_RD;
        end
      end

      S_ALLOC_RD: begin
        run_addr = cur_q;
        lk_addr  = cur_q;
        state_d  = S_ALLOC_CMP;
      end

      // Check the run; unlink it on a fit, else follow the list or go to the next class
      S_ALLOC_CMP: begin
        if (rd_len >= pages_q) begin
          status_d = ST_GRANTED;
          gp_d     = rd_start;
          gc_d     = rd_len;
          in_use_d[cur_q] = 1'b0;
          state_d  = S_IDLE;
          ovalid_d = 1'b1;
          if (!have_prev_q) begin
            if (has_next) begin
              head_d[cix] = lk_rd;
            end else begin
              nonempty_d[cix] = 1'b0;
              if (c_q == top_q) begin
                ovalid_d = 1'b0;
                state_d  = S_LOWER;
              end
            end
          end else begin
            lk_we            = 1'b1;
            lk_addr          = prev_q;
            lk_wdata         = lk_rd;
            lvalid_d[prev_q] = has_next;
            if (!has_next) begin
              tail_d[cix] = prev_q;
            end
          end
          lvalid_d[cur_q] = 1'b0;
        end else if (!has_next) begin
          c_d     = c_q + 1'b1;
          state_d = S_ALLOC_CHK;
        end else begin
          prev_d      = cur_q;
          have_prev_d = 1'b1;
          cur_d       = lk_rd;
          state_d     = S_ALLOC_RD;
        end
      end

      // Walk down to the highest non-empty class
      S_LOWER: begin
        if (nonempty_q[cix]) begin
          top_d    = c_q;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end else if (c_q == '0) begin
          top_d    = NO_CLASS;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          c_d = c_q - 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      top_q      <= NO_CLASS;
      base_q     <= 5'd8;
      in_use_q   <= '0;
      lvalid_q   <= '0;
      nonempty_q <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      base_q     <= base_d;
      in_use_q   <= in_use_d;
      lvalid_q   <= lvalid_d;
      nonempty_q <= nonempty_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    type_q      <= type_d;
    spage_q     <= spage_d;
    pages_q     <= pages_d;
    c_q         <= c_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    have_prev_q <= have_prev_d;
    cnt_q       <= cnt_d;
    slot_q      <= slot_d;
    found_q     <= found_d;
    head_q      <= head_d;
    tail_q      <= tail_d;
    status_q    <= status_d;
    gp_q        <= gp_d;
    gc_q        <= gc_d;
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = status_q;
  assign granted_page_o  = gp_q;
  assign granted_count_o = gc_q;

endmodule
